### rtl/core/afr_pkg.sv
// Package for the API frame receiver: field widths, kind and event codes,
// receive phases and the control bundle passed from the parser to the top level.
// No dependencies.
package afr_pkg;

    localparam int MAX_PAYLOAD = 128;
    localparam int STORE_AW    = $clog2(MAX_PAYLOAD);

    localparam int S_TDATA_W = 16;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 24;

    localparam logic [7:0] START_MARK = 8'h7E;
    localparam logic [7:0] CHECK_BASE = 8'hFF;
    localparam logic [7:0] MIN_LENGTH = 8'd3;
    localparam logic [7:0] MAX_LENGTH = 8'(MAX_PAYLOAD);

    localparam logic [1:0] KIND_BYTE    = 2'd0;
    localparam logic [1:0] KIND_READ    = 2'd1;
    localparam logic [1:0] KIND_RELEASE = 2'd2;

    localparam logic [2:0] EV_NONE       = 3'd0;
    localparam logic [2:0] EV_GOOD       = 3'd1;
    localparam logic [2:0] EV_CHECK_BAD  = 3'd2;
    localparam logic [2:0] EV_LENGTH_BAD = 3'd3;
    localparam logic [2:0] EV_REFUSED    = 3'd4;

    typedef enum logic [3:0] {
        PH_HUNT   = 4'b0001,
        PH_LEN_HI = 4'b0010,
        PH_LEN_LO = 4'b0100,
        PH_BODY   = 4'b1000
    } phase_t;

    typedef struct packed {
        logic [2:0]          ev;
        logic [7:0]          held;
        logic                wr_en;
        logic [STORE_AW-1:0] wr_addr;
        logic [7:0]          wr_data;
        logic                rd_en;
        logic [STORE_AW-1:0] rd_addr;
        logic                rd_ok;
    } afr_ctrl_t;

endpackage

### rtl/core/api_frame_receiver_unit.sv
// Top level of the API frame receiver: parser, payload store and result pipeline.
// Depends on afr_pkg, afr_parser and afr_ram.
//
// Usage:
//   Slave channel: one transaction per item. s_tuser carries the kind (received
//   serial byte, read held payload byte, release held frame); s_tdata carries
//   the received byte and the read index.
//   Master channel: one result transaction per input transaction, in order:
//   event code, frame-ready flag, held frame length and read data.
//   Pipeline: an accepted input transaction passes through the parse stage
//   (with the payload store read register) and then the output register
//   before its result appears on m_tvalid.
//   Throughput: one transaction per cycle unless m_tready stalls the output;
//   the registered read of the payload store places the read data in the
//   parse stage, and the output register parts the slave and master channels.
//   Reset: aresetn low clears the receive state, drops any held frame and
//   empties the pipeline. The payload store keeps its contents; only entries
//   written by a verified frame are ever returned.
//   Stall: when m_tready is low the result holds; one more transaction is
//   taken into the parse stage, then s_tready drops until the result drains.
module api_frame_receiver_unit (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [afr_pkg::S_TDATA_W-1:0]  s_tdata,  // rx_byte[7:0], read_index[14:8], 0
    input  logic [afr_pkg::S_TUSER_W-1:0]  s_tuser,  // kind[1:0]
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // event_res[2:0], frame_ready[3], frame_length[11:4], read_data[19:12], 0
    output logic [afr_pkg::M_TDATA_W-1:0]  m_tdata
);

    import afr_pkg::*;

    afr_ctrl_t              ctrl;
    logic                   accept;
    logic                   advance;
    logic [7:0]             ram_q;
    logic                   a_valid_reg;
    logic [2:0]             a_ev_reg;
    logic [7:0]             a_held_reg;
    logic                   a_rd_ok_reg;
    logic                   m_valid_reg;
    logic [M_TDATA_W-1:0]   m_data_reg;
    logic [M_TDATA_W-1:0]   m_data_next;

    assign advance  = a_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !a_valid_reg || advance;
    assign accept   = s_tvalid && s_tready;

    afr_parser u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (accept),
        .kind       (s_tuser[1:0]),
        .rx_byte    (s_tdata[7:0]),
        .read_index (s_tdata[14:8]),
        .ctrl       (ctrl)
    );

    afr_ram #(
        .WIDTH (8),
        .DEPTH (MAX_PAYLOAD)
    ) u_store (
        .clk   (aclk),
        .we    (ctrl.wr_en),
        .waddr (ctrl.wr_addr),
        .wdata (ctrl.wr_data),
        .re    (ctrl.rd_en),
        .raddr (ctrl.rd_addr),
        .rdata (ram_q)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (accept) begin
            a_valid_reg <= 1'b1;
        end else if (advance) begin
            a_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            a_ev_reg    <= ctrl.ev;
            a_held_reg  <= ctrl.held;
            a_rd_ok_reg <= ctrl.rd_ok;
        end
    end

    assign m_data_next = {
        4'd0,
        a_rd_ok_reg ? ram_q : 8'd0,
        a_held_reg,
        a_held_reg != 8'd0,
        a_ev_reg
    };

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    a_ready_matches_length: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[3] == (m_tdata[11:4] != 8'd0)))
        else $error("frame_ready disagrees with frame_length");

    a_length_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[11:4] <= MAX_LENGTH))
        else $error("held length above maximum payload");

    a_good_sets_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata[2:0] == EV_GOOD || m_tdata[2:0] == EV_REFUSED))
        |-> m_tdata[3])
        else $error("good or refused event without a held frame");

    a_stage_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        (a_valid_reg && m_tready) |=> m_tvalid)
        else $error("parse stage did not move to the output register");

endmodule

### rtl/core/afr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module afr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/core/afr_parser.sv
// Frame parser: receive phase, length, running sum and held-frame state.
// Depends on afr_pkg.
module afr_parser (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               accept,
    input  logic [1:0]         kind,
    input  logic [7:0]         rx_byte,
    input  logic [6:0]         read_index,
    output afr_pkg::afr_ctrl_t ctrl
);

    import afr_pkg::*;

    phase_t     phase_reg, phase_next;
    logic [7:0] count_reg, count_next;
    logic [7:0] decl_reg, decl_next;
    logic [7:0] sum_reg, sum_next;
    logic [7:0] held_reg, held_next;
    logic [2:0] ev;
    logic       wr_hit;
    logic       rd_hit;
    logic       rd_ok;

    always_comb begin
        phase_next = phase_reg;
        count_next = count_reg;
        decl_next  = decl_reg;
        sum_next   = sum_reg;
        held_next  = held_reg;
        ev         = EV_NONE;
        wr_hit     = 1'b0;
        rd_hit     = 1'b0;
        rd_ok      = 1'b0;
        case (kind)
            KIND_BYTE: begin
                if (held_reg != 8'd0) begin
                    ev = EV_REFUSED;
                end else begin
                    unique case (phase_reg)
                        PH_HUNT: begin
                            if (rx_byte == START_MARK) begin
                                phase_next = PH_LEN_HI;
                                count_next = 8'd0;
                                sum_next   = 8'd0;
                            end
                        end
                        PH_LEN_HI: begin
                            phase_next = PH_LEN_LO;
                        end
                        PH_LEN_LO: begin
                            if (rx_byte < MIN_LENGTH || rx_byte > MAX_LENGTH) begin
                                phase_next = PH_HUNT;
                                ev         = EV_LENGTH_BAD;
                            end else begin
                                decl_next  = rx_byte;
                                count_next = 8'd0;
                                sum_next   = 8'd0;
                                phase_next = PH_BODY;
                            end
                        end
                        PH_BODY: begin
                            if (count_reg < decl_reg && count_reg < MAX_LENGTH) begin
                                wr_hit     = 1'b1;
                                sum_next   = sum_reg + rx_byte;
                                count_next = count_reg + 8'd1;
                            end else begin
                                phase_next = PH_HUNT;
                                count_next = 8'd0;
                                if (CHECK_BASE - sum_reg != rx_byte) begin
                                    ev = EV_CHECK_BAD;
                                end else begin
                                    held_next = decl_reg;
                                    ev        = EV_GOOD;
                                end
                            end
                        end
                        default: begin
                            phase_next = PH_HUNT;
                        end
                    endcase
                end
            end
            KIND_READ: begin
                rd_hit = 1'b1;
                rd_ok  = (held_reg != 8'd0) && ({1'b0, read_index} < held_reg);
            end
            KIND_RELEASE: begin
                held_next = 8'd0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HUNT;
            count_reg <= 8'd0;
            decl_reg  <= 8'd0;
            sum_reg   <= 8'd0;
            held_reg  <= 8'd0;
        end else if (accept) begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            decl_reg  <= decl_next;
            sum_reg   <= sum_next;
            held_reg  <= held_next;
        end
    end

    assign ctrl.ev      = ev;
    assign ctrl.held    = held_next;
    assign ctrl.wr_en   = accept && wr_hit;
    assign ctrl.wr_addr = count_reg[STORE_AW-1:0];
    assign ctrl.wr_data = rx_byte;
    assign ctrl.rd_en   = accept && rd_hit;
    assign ctrl.rd_addr = STORE_AW'(read_index);
    assign ctrl.rd_ok   = rd_ok;

endmodule

### sim/testbench.sv
// Self-checking testbench for api_frame_receiver_unit: directed and random frame traffic,
// each result checked field by field against a built-in frame deframer.
// Depends on afr_pkg and the api_frame_receiver_unit RTL.
`timescale 1ns / 100ps

module testbench;
    import afr_pkg::*;

    localparam logic [1:0] KIND_SPARE = 2'd3;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] rx_byte;
        logic [6:0] read_index;
    } rx_item_t;

    typedef struct packed {
        logic [2:0] event_res;
        logic       frame_ready;
        logic [7:0] frame_length;
        logic [7:0] read_data;
    } frame_result_t;

    logic                   aclk     = 1'b0;
    logic                   aresetn  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata  = '0;
    logic [S_TUSER_W-1:0]   s_tuser  = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;

    // deframer state
    phase_t     rx_phase    = PH_HUNT;
    logic [7:0] rx_count    = '0;
    logic [7:0] rx_declared = '0;
    logic [7:0] rx_sum      = '0;
    logic [7:0] held_len    = '0;
    logic [7:0] payload_copy [MAX_PAYLOAD];

    frame_result_t frame_outcomes [$];
    int            failures          = 0;
    int            sent_items        = 0;
    int            idle_pct          = 0;
    int            stall_pct         = 0;
    int            hold_off_request  = 0;
    int            hold_off_left     = 0;

    api_frame_receiver_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #10 aclk = ~aclk;

    initial begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

    function automatic frame_result_t deframe_step(input rx_item_t it);
        frame_result_t r;
        r = '0;
        case (it.kind)
            KIND_BYTE: begin
                if (held_len != 0) begin
                    r.event_res = EV_REFUSED;
                end else begin
                    case (rx_phase)
                        PH_HUNT: begin
                            if (it.rx_byte == START_MARK) begin
                                rx_phase = PH_LEN_HI;
                                rx_count = '0;
                                rx_sum   = '0;
                            end
                        end
                        PH_LEN_HI: rx_phase = PH_LEN_LO;
                        PH_LEN_LO: begin
                            if (it.rx_byte < MIN_LENGTH || it.rx_byte > MAX_LENGTH) begin
                                rx_phase    = PH_HUNT;
                                r.event_res = EV_LENGTH_BAD;
                            end else begin
                                rx_declared = it.rx_byte;
                                rx_count    = '0;
                                rx_sum      = '0;
                                rx_phase    = PH_BODY;
                            end
                        end
                        default: begin
                            if (rx_count < rx_declared) begin
                                payload_copy[rx_count[STORE_AW-1:0]] = it.rx_byte;
                                rx_sum   = rx_sum + it.rx_byte;
                                rx_count = rx_count + 8'd1;
                            end else begin
                                rx_phase = PH_HUNT;
                                rx_count = '0;
                                if (8'(CHECK_BASE - rx_sum) == it.rx_byte) begin
                                    held_len    = rx_declared;
                                    r.event_res = EV_GOOD;
                                end else begin
                                    r.event_res = EV_CHECK_BAD;
                                end
                            end
                        end
                    endcase
                end
            end
            KIND_READ: begin
                if (held_len != 0 && it.read_index < held_len)
                    r.read_data = payload_copy[it.read_index];
            end
            KIND_RELEASE: held_len = '0;
            default: ;
        endcase
        r.frame_ready  = (held_len != 0);
        r.frame_length = held_len;
        return r;
    endfunction

    // receiver: random stalls, or a long hold-off on request
    always @(posedge aclk) begin
        if (hold_off_request != 0) begin
            hold_off_left    = hold_off_request;
            hold_off_request = 0;
        end
        if (hold_off_left != 0) begin
            hold_off_left = hold_off_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            failures++;
        end
    endtask

    always @(posedge aclk) begin : result_check
        frame_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (frame_outcomes.size() == 0) begin
                $error("result transaction with nothing outstanding: %h", m_tdata);
                failures++;
            end else begin
                want = frame_outcomes.pop_front();
                check_field("event_res", want.event_res, m_tdata[2:0]);
                check_field("frame_ready", want.frame_ready, m_tdata[3]);
                check_field("frame_length", want.frame_length, m_tdata[11:4]);
                check_field("read_data", want.read_data, m_tdata[19:12]);
            end
        end
    end

    task automatic send_item(input logic [1:0] kind, input logic [7:0] rx,
                             input logic [6:0] idx);
        rx_item_t it;
        it = '{kind: kind, rx_byte: rx, read_index: idx};
        s_tuser  <= kind;
        s_tdata  <= {1'b0, idx, rx};
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        frame_outcomes.push_back(deframe_step(it));
        if (kind != KIND_SPARE) sent_items++;
        if ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < idle_pct);
        end
    endtask

    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        while (frame_outcomes.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic send_frame(input int len, input bit corrupt);
        logic [7:0] sum, b, chk;
        sum = '0;
        send_item(KIND_BYTE, START_MARK, 7'($urandom));
        send_item(KIND_BYTE, 8'($urandom), 7'($urandom));
        send_item(KIND_BYTE, 8'(len), 7'($urandom));
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(99) < 3)
                send_item(2'($urandom_range(1, 3)), 8'($urandom), 7'($urandom));
            b   = 8'($urandom);
            sum = sum + b;
            send_item(KIND_BYTE, b, 7'($urandom));
        end
        chk = CHECK_BASE - sum;
        if (corrupt) chk = chk ^ 8'(1 << $urandom_range(7));
        send_item(KIND_BYTE, chk, 7'($urandom));
    endtask

    task automatic read_and_release();
        int n, lim;
        n = $urandom_range(1, 6);
        repeat (n) begin
            lim = held_len;
            if (lim == 0 || $urandom_range(3) == 0)
                send_item(KIND_READ, 8'($urandom), 7'($urandom));
            else
                send_item(KIND_READ, 8'($urandom), 7'($urandom_range(lim - 1)));
        end
        if ($urandom_range(4) == 0)
            repeat ($urandom_range(1, 3)) send_item(KIND_BYTE, 8'($urandom), 7'($urandom));
        send_item(KIND_RELEASE, 8'($urandom), 7'($urandom));
    endtask

    task automatic test_good_frame();
        idle_pct  = 0;
        stall_pct = 0;
        send_item(KIND_BYTE, 8'h00, 7'd0);
        send_item(KIND_BYTE, START_MARK, 7'd0);
        send_item(KIND_BYTE, 8'hFF, 7'd0);
        send_item(KIND_BYTE, 8'd3, 7'd0);
        send_item(KIND_BYTE, 8'h00, 7'd0);
        send_item(KIND_BYTE, 8'hFF, 7'd0);
        send_item(KIND_BYTE, 8'h80, 7'd0);
        send_item(KIND_BYTE, 8'h80, 7'd0);
        send_item(KIND_READ, 8'h00, 7'd0);
        send_item(KIND_READ, 8'h00, 7'd2);
        send_item(KIND_READ, 8'h00, 7'd3);
        send_item(KIND_READ, 8'hFF, 7'd127);
        send_item(KIND_BYTE, START_MARK, 7'd0);
        send_item(KIND_RELEASE, 8'h00, 7'd0);
        send_item(KIND_RELEASE, 8'h00, 7'd0);
        send_item(KIND_READ, 8'h00, 7'd1);
        wait_for_results();
    endtask

    task automatic test_rejected_frames();
        send_item(KIND_BYTE, START_MARK, 7'd0);
        send_item(KIND_BYTE, 8'h00, 7'd0);
        send_item(KIND_BYTE, 8'd2, 7'd0);
        send_item(KIND_BYTE, START_MARK, 7'd0);
        send_item(KIND_BYTE, 8'h00, 7'd0);
        send_item(KIND_BYTE, 8'd129, 7'd0);
        send_item(KIND_SPARE, 8'hFF, 7'h7F);
        send_item(KIND_BYTE, START_MARK, 7'd0);
        send_item(KIND_BYTE, 8'h00, 7'd0);
        send_item(KIND_BYTE, 8'd3, 7'd0);
        send_item(KIND_BYTE, 8'h01, 7'd0);
        send_item(KIND_BYTE, 8'h02, 7'd0);
        send_item(KIND_BYTE, 8'h03, 7'd0);
        send_item(KIND_BYTE, 8'h00, 7'd0);
        wait_for_results();
    endtask

    task automatic test_longest_frame();
        idle_pct  = 14;
        stall_pct = 14;
        send_frame(MAX_PAYLOAD, 1'b0);
        send_item(KIND_READ, 8'($urandom), 7'd0);
        send_item(KIND_READ, 8'($urandom), 7'd127);
        send_item(KIND_RELEASE, 8'($urandom), 7'($urandom));
        wait_for_results();
    endtask

    task automatic test_backpressure();
        idle_pct         = 0;
        stall_pct        = 0;
        hold_off_request = 60;
        send_frame(10, 1'b0);
        read_and_release();
        wait_for_results();
    endtask

    task automatic run_random_traffic(input int send_idle, input int recv_stall, input int n);
        int stop_at, pick, len;
        idle_pct  = send_idle;
        stall_pct = recv_stall;
        stop_at   = sent_items + n;
        while (sent_items < stop_at) begin
            pick = $urandom_range(99);
            if (pick < 8) begin
                send_item(KIND_BYTE, 8'($urandom), 7'($urandom));
            end else if (pick < 11) begin
                send_item(KIND_SPARE, 8'($urandom), 7'($urandom));
            end else if (pick < 14) begin
                send_item(KIND_RELEASE, 8'($urandom), 7'($urandom));
            end else if (pick < 20) begin
                len = $urandom_range(1) ? $urandom_range(2) : $urandom_range(129, 255);
                send_item(KIND_BYTE, START_MARK, 7'($urandom));
                send_item(KIND_BYTE, 8'($urandom), 7'($urandom));
                send_item(KIND_BYTE, 8'(len), 7'($urandom));
            end else begin
                pick = $urandom_range(99);
                len  = (pick < 2) ? MAX_PAYLOAD :
                       (pick < 10) ? $urandom_range(17, 127) : $urandom_range(3, 16);
                send_frame(len, $urandom_range(99) < 15);
                read_and_release();
            end
        end
        wait_for_results();
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_good_frame();
        test_rejected_frames();
        test_longest_frame();
        test_backpressure();
        run_random_traffic(0, 0, 130);
        run_random_traffic(53, 0, 130);
        run_random_traffic(0, 53, 130);
        run_random_traffic(14, 14, 130);
        if (failures == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
